[src/gpmd_pkg.sv]
// ----------------------------------------------------------------------------
// gpmd_pkg
// Types, message codes and helpers shared by the GNSS position decoder.
// ----------------------------------------------------------------------------
package gpmd_pkg;

  // Width of the internal position accumulators (legal range 32 to 64).
  localparam int unsigned AccumWidth = 40;
  // Width of the position fields on the result channel.
  localparam int unsigned PosWidth   = 40;

  localparam logic [17:0] PgnPosition        = 18'd65267;
  localparam logic [17:0] PgnDelta           = 18'd65268;
  localparam logic [17:0] PgnDeltaWide       = 18'd65269;
  localparam logic [17:0] PgnCovariance      = 18'd65270;
  localparam logic [17:0] PgnDeltaCovariance = 18'd65271;

  // Minimum payload lengths for the various message parts.
  localparam logic [6:0] LenPosition = 7'd8;
  localparam logic [6:0] LenAltitude = 7'd12;
  localparam logic [6:0] LenSats     = 7'd14;
  localparam logic [6:0] LenHdop     = 7'd15;
  localparam logic [6:0] LenStatus   = 7'd16;
  localparam logic [6:0] LenDelta    = 7'd8;
  localparam logic [6:0] LenWide     = 7'd12;

  // Scale factors for the short delta message.
  localparam logic signed [31:0] DegScale = 32'sd1000;
  localparam logic signed [31:0] AltScale = 32'sd10;

  typedef enum logic [2:0] {
    FixNone     = 3'd0,
    FixGps      = 3'd1,
    FixDgps     = 3'd2,
    FixRtkFloat = 3'd3,
    FixRtkFixed = 3'd4
  } fix_e;

  typedef logic signed [AccumWidth-1:0] acc_t;

  typedef struct packed {
    logic [17:0] pgn;
    logic [6:0]  length;
    logic [63:0] payload_low;
    logic [63:0] payload_high;
  } in_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [PosWidth-1:0] latitude;
    logic signed [PosWidth-1:0] longitude;
    logic signed [PosWidth-1:0] altitude;
    logic                       position_present;
    logic                       altitude_present;
    logic [7:0]                 satellites;
    logic [7:0]                 hdop_hundredths;
    fix_e                       fix_quality;
    logic                       solution_valid;
  } out_t;

  // Saturating add of a 32-bit signed delta to an accumulator.
  function automatic acc_t sat_add(acc_t acc, logic signed [31:0] delta);
    logic signed [AccumWidth:0] sum;
    acc_t                       res;
    sum = $signed({acc[AccumWidth-1], acc}) +
          $signed({{(AccumWidth-31){delta[31]}}, delta});
    if (sum[AccumWidth] != sum[AccumWidth-1]) begin
      res = sum[AccumWidth] ? {1'b1, {(AccumWidth-1){1'b0}}}
                            : {1'b0, {(AccumWidth-1){1'b1}}};
    end else begin
      res = sum[AccumWidth-1:0];
    end
    return res;
  endfunction

endpackage

[src/gnss_position_message_decoder_core.sv]
// ----------------------------------------------------------------------------
// gnss_position_message_decoder_core
// Decodes GNSS position, delta and covariance messages into a running,
// saturating position solution.
// ----------------------------------------------------------------------------
// Path: an input transfer reaches the earliest result transfer through the
// input register, then the state and result register.
// Throughput: one message per cycle while the result side is ready; the
// combinational accumulator update between the input register and the state registers sets this.
// Reset: asynchronous, active low; clears the solution and both valid flags.
module gnss_position_message_decoder_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  gpmd_pkg::in_t   in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output gpmd_pkg::out_t  out_o
);

  // Input register.
  logic          in_valid_q;
  gpmd_pkg::in_t in_q;

  // Solution state; the result fields are read straight from it, since it
  // only changes when a new result is loaded.
  gpmd_pkg::acc_t lat_q, lat_d;
  gpmd_pkg::acc_t lon_q, lon_d;
  gpmd_pkg::acc_t alt_q, alt_d;
  logic           pos_set_q, pos_set_d;
  logic           alt_set_q, alt_set_d;
  logic [7:0]     sat_q, sat_d;
  logic [7:0]     hdop_q, hdop_d;
  gpmd_pkg::fix_e fix_q, fix_d;
  logic           sol_valid_q, sol_valid_d;

  logic out_valid_q;
  logic accepted_q, accepted_d;
  logic advance;

  logic [127:0]      pl;
  logic [7:0]        status;
  logic signed [31:0] lat_s16, lon_s16, alt_s16;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  assign pl      = {in_q.payload_high, in_q.payload_low};
  assign status  = pl[127:120];
  assign lat_s16 = 32'($signed(pl[15:0])) * gpmd_pkg::DegScale;
  assign lon_s16 = 32'($signed(pl[31:16])) * gpmd_pkg::DegScale;
  assign alt_s16 = 32'($signed(pl[47:32])) * gpmd_pkg::AltScale;

  always_comb begin
    lat_d       = lat_q;
    lon_d       = lon_q;
    alt_d       = alt_q;
    pos_set_d   = pos_set_q;
    alt_set_d   = alt_set_q;
    sat_d       = sat_q;
    hdop_d      = hdop_q;
    fix_d       = fix_q;
    sol_valid_d = sol_valid_q;
    accepted_d  = 1'b0;
    unique case (in_q.pgn) inside
      gpmd_pkg::PgnPosition: begin
        if (in_q.length >= gpmd_pkg::LenPosition) begin
          accepted_d  = 1'b1;
          lat_d       = gpmd_pkg::AccumWidth'($signed(pl[31:0]));
          lon_d       = gpmd_pkg::AccumWidth'($signed(pl[63:32]));
          pos_set_d   = 1'b1;
          sol_valid_d = 1'b1;
          if (in_q.length >= gpmd_pkg::LenAltitude) begin
            alt_d     = gpmd_pkg::AccumWidth'($signed(pl[95:64]));
            alt_set_d = 1'b1;
          end
          if (in_q.length >= gpmd_pkg::LenSats) begin
            sat_d = pl[111:104];
          end
          if (in_q.length >= gpmd_pkg::LenHdop) begin
            hdop_d = pl[119:112];
          end
          // Status byte: RTK fixed wins over float over DGPS; GPS alone
          // applies only when none of those bits is set.
          if (in_q.length >= gpmd_pkg::LenStatus) begin
            if (status[2]) begin
              fix_d = gpmd_pkg::FixRtkFixed;
            end else if (status[3]) begin
              fix_d = gpmd_pkg::FixRtkFloat;
            end else if (status[1]) begin
              fix_d = gpmd_pkg::FixDgps;
            end else if (status[0]) begin
              fix_d = gpmd_pkg::FixGps;
            end
          end
        end
      end
      gpmd_pkg::PgnDelta: begin
        if (in_q.length >= gpmd_pkg::LenDelta) begin
          accepted_d = 1'b1;
          if (pos_set_q) begin
            lat_d = gpmd_pkg::sat_add(lat_q, lat_s16);
            lon_d = gpmd_pkg::sat_add(lon_q, lon_s16);
          end
          if (alt_set_q) begin
            alt_d = gpmd_pkg::sat_add(alt_q, alt_s16);
          end
        end
      end
      gpmd_pkg::PgnDeltaWide: begin
        if (in_q.length >= gpmd_pkg::LenWide) begin
          accepted_d = 1'b1;
          if (pos_set_q) begin
            lat_d = gpmd_pkg::sat_add(lat_q, $signed(pl[31:0]));
            lon_d = gpmd_pkg::sat_add(lon_q, $signed(pl[63:32]));
          end
          if (alt_set_q) begin
            alt_d = gpmd_pkg::sat_add(alt_q, $signed(pl[95:64]));
          end
        end
      end
      gpmd_pkg::PgnCovariance, gpmd_pkg::PgnDeltaCovariance: begin
        accepted_d = 1'b1;
      end
      default: begin
        accepted_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      alt_q       <= '0;
      pos_set_q   <= 1'b0;
      alt_set_q   <= 1'b0;
      sat_q       <= '0;
      hdop_q      <= '0;
      fix_q       <= gpmd_pkg::FixNone;
      sol_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        accepted_q  <= accepted_d;
        lat_q       <= lat_d;
        lon_q       <= lon_d;
        alt_q       <= alt_d;
        pos_set_q   <= pos_set_d;
        alt_set_q   <= alt_set_d;
        sat_q       <= sat_d;
        hdop_q      <= hdop_d;
        fix_q       <= fix_d;
        sol_valid_q <= sol_valid_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sign-extend or truncate the accumulators to the result field width.
  logic signed [63:0] lat_ext, lon_ext, alt_ext;
  assign lat_ext = 64'(lat_q);
  assign lon_ext = 64'(lon_q);
  assign alt_ext = 64'(alt_q);

  assign out_valid_o              = out_valid_q;
  assign out_o.accepted           = accepted_q;
  assign out_o.latitude           = lat_ext[gpmd_pkg::PosWidth-1:0];
  assign out_o.longitude          = lon_ext[gpmd_pkg::PosWidth-1:0];
  assign out_o.altitude           = alt_ext[gpmd_pkg::PosWidth-1:0];
  assign out_o.position_present   = pos_set_q;
  assign out_o.altitude_present   = alt_set_q;
  assign out_o.satellites         = sat_q;
  assign out_o.hdop_hundredths    = hdop_q;
  assign out_o.fix_quality        = fix_q;
  assign out_o.solution_valid     = sol_valid_q;

`ifndef SYNTHESIS
  // A held input item must not be overwritten before it is consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register overwritten while stalled");

  // A full solution always carries a position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sol_valid_q |-> pos_set_q)
    else $error("solution valid without position");

  // A rejected message leaves the accumulators alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !accepted_d |=> $stable(lat_q) && $stable(lon_q) && $stable(alt_q))
    else $error("rejected message changed the solution");

  // State only moves when a new result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(lat_q) && $stable(pos_set_q) && $stable(fix_q))
    else $error("solution changed without a result transfer");

  // A long enough position message always sets the position flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.pgn == gpmd_pkg::PgnPosition &&
    in_q.length >= gpmd_pkg::LenPosition |=> pos_set_q && sol_valid_q && accepted_q)
    else $error("position message did not set the solution");
`endif

endmodule

[tb/gpmd_solution_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gpmd_solution_checker
// Watches both channels of the GNSS position decoder, keeps its own copy of
// the running position solution and compares every result transfer with it.
// ----------------------------------------------------------------------------
module gpmd_solution_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  gpmd_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  gpmd_pkg::out_t out_data_i,
  output int             error_count_o,
  output int             pending_o,
  output int             checked_o,
  output int             clamp_count_o
);

  gpmd_pkg::acc_t lat_now;
  gpmd_pkg::acc_t lon_now;
  gpmd_pkg::acc_t alt_now;
  logic           have_pos;
  logic           have_alt;
  logic [7:0]     sats_now;
  logic [7:0]     hdop_now;
  gpmd_pkg::fix_e fix_now;
  logic           seen_full;

  gpmd_pkg::out_t solutions_due[$];
  gpmd_pkg::out_t due_now;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
    checked_o     = 0;
    clamp_count_o = 0;
  end

  function automatic longint word32(logic [31:0] w);
    return longint'(signed'(w));
  endfunction

  function automatic longint word16(logic [15:0] w);
    return longint'(signed'(w));
  endfunction

  // Adds a delta and clamps to the signed accumulator range.
  function automatic gpmd_pkg::acc_t clamp_add(gpmd_pkg::acc_t acc, longint delta);
    longint sum;
    longint top;
    longint bottom;
    top    = (longint'(1) <<< (gpmd_pkg::AccumWidth - 1)) - 1;
    bottom = -top - 1;
    sum    = longint'(acc) + delta;
    if (sum > top) begin
      clamp_count_o++;
      return gpmd_pkg::acc_t'(top);
    end
    if (sum < bottom) begin
      clamp_count_o++;
      return gpmd_pkg::acc_t'(bottom);
    end
    return gpmd_pkg::acc_t'(sum);
  endfunction

  // Applies one message to the solution and returns the result it should give.
  function automatic gpmd_pkg::out_t update_solution(gpmd_pkg::in_t msg);
    gpmd_pkg::out_t res;
    logic           ok;
    logic [7:0]     status;
    ok     = 1'b0;
    status = msg.payload_high[63:56];
    case (msg.pgn) inside
      gpmd_pkg::PgnPosition: begin
        if (msg.length >= gpmd_pkg::LenPosition) begin
          ok        = 1'b1;
          lat_now   = gpmd_pkg::acc_t'(word32(msg.payload_low[31:0]));
          lon_now   = gpmd_pkg::acc_t'(word32(msg.payload_low[63:32]));
          have_pos  = 1'b1;
          seen_full = 1'b1;
          if (msg.length >= gpmd_pkg::LenAltitude) begin
            alt_now  = gpmd_pkg::acc_t'(word32(msg.payload_high[31:0]));
            have_alt = 1'b1;
          end
          if (msg.length >= gpmd_pkg::LenSats) sats_now = msg.payload_high[47:40];
          if (msg.length >= gpmd_pkg::LenHdop) hdop_now = msg.payload_high[55:48];
          if (msg.length >= gpmd_pkg::LenStatus) begin
            // Plain GPS is taken first, then any RTK or DGPS bit overrides it.
            if (status[0]) fix_now = gpmd_pkg::FixGps;
            if (status[2]) begin
              fix_now = gpmd_pkg::FixRtkFixed;
            end else if (status[3]) begin
              fix_now = gpmd_pkg::FixRtkFloat;
            end else if (status[1]) begin
              fix_now = gpmd_pkg::FixDgps;
            end
          end
        end
      end
      gpmd_pkg::PgnDelta: begin
        if (msg.length >= gpmd_pkg::LenDelta) begin
          ok = 1'b1;
          if (have_pos) begin
            lat_now = clamp_add(lat_now, word16(msg.payload_low[15:0]) *
                                         longint'(gpmd_pkg::DegScale));
            lon_now = clamp_add(lon_now, word16(msg.payload_low[31:16]) *
                                         longint'(gpmd_pkg::DegScale));
          end
          if (have_alt) begin
            alt_now = clamp_add(alt_now, word16(msg.payload_low[47:32]) *
                                         longint'(gpmd_pkg::AltScale));
          end
        end
      end
      gpmd_pkg::PgnDeltaWide: begin
        if (msg.length >= gpmd_pkg::LenWide) begin
          ok = 1'b1;
          if (have_pos) begin
            lat_now = clamp_add(lat_now, word32(msg.payload_low[31:0]));
            lon_now = clamp_add(lon_now, word32(msg.payload_low[63:32]));
          end
          if (have_alt) alt_now = clamp_add(alt_now, word32(msg.payload_high[31:0]));
        end
      end
      gpmd_pkg::PgnCovariance, gpmd_pkg::PgnDeltaCovariance: begin
        ok = 1'b1;
      end
      default: begin
      end
    endcase
    res.accepted         = ok;
    res.latitude         = lat_now[gpmd_pkg::PosWidth-1:0];
    res.longitude        = lon_now[gpmd_pkg::PosWidth-1:0];
    res.altitude         = alt_now[gpmd_pkg::PosWidth-1:0];
    res.position_present = have_pos;
    res.altitude_present = have_alt;
    res.satellites       = sats_now;
    res.hdop_hundredths  = hdop_now;
    res.fix_quality      = fix_now;
    res.solution_valid   = seen_full;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count_o++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_now   = '0;
      lon_now   = '0;
      alt_now   = '0;
      have_pos  = 1'b0;
      have_alt  = 1'b0;
      sats_now  = '0;
      hdop_now  = '0;
      fix_now   = gpmd_pkg::FixNone;
      seen_full = 1'b0;
      solutions_due.delete();
      pending_o = 0;
    end else begin
      // Results are taken before new messages: with the pipeline latency a
      // result never belongs to a message accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (solutions_due.size() == 0) begin
          error_count_o++;
          $error("result transfer with no message outstanding");
        end else begin
          due_now = solutions_due.pop_front();
          check_field("accepted", due_now.accepted, out_data_i.accepted);
          check_field("latitude", due_now.latitude, out_data_i.latitude);
          check_field("longitude", due_now.longitude, out_data_i.longitude);
          check_field("altitude", due_now.altitude, out_data_i.altitude);
          check_field("position_present", due_now.position_present,
                      out_data_i.position_present);
          check_field("altitude_present", due_now.altitude_present,
                      out_data_i.altitude_present);
          check_field("satellites", due_now.satellites, out_data_i.satellites);
          check_field("hdop_hundredths", due_now.hdop_hundredths,
                      out_data_i.hdop_hundredths);
          check_field("fix_quality", due_now.fix_quality, out_data_i.fix_quality);
          check_field("solution_valid", due_now.solution_valid,
                      out_data_i.solution_valid);
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) solutions_due.push_back(update_solution(in_data_i));
      pending_o = solutions_due.size();
    end
  end

endmodule

[tb/tb_gnss_position_message_decoder_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gnss_position_message_decoder_core
// Drives position, delta, covariance and malformed messages into the decoder
// under several idle and stall patterns; the checker beside it predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_gnss_position_message_decoder_core;

  localparam int PhaseItems = 328;
  localparam int DriftSteps = 270;
  localparam int HoldLen    = 150;
  localparam int CycleLimit = 400000;

  logic           clk         = 1'b0;
  logic           rst_n       = 1'b0;
  logic           in_valid    = 1'b0;
  logic           in_ready;
  gpmd_pkg::in_t  in_data     = '0;
  logic           out_valid;
  logic           out_ready   = 1'b0;
  gpmd_pkg::out_t out_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit long_hold      = 1'b0;
  bit hold_served    = 1'b0;
  int msgs_sent      = 0;
  int directed_count = 0;
  int cycle_count    = 0;

  int n_errors;
  int n_pending;
  int n_checked;
  int n_clamped;

  always #2 clk = ~clk;

  gnss_position_message_decoder_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_data)
  );

  gpmd_solution_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .error_count_o(n_errors),
    .pending_o    (n_pending),
    .checked_o    (n_checked),
    .clamp_count_o(n_clamped)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic gpmd_pkg::in_t make_msg(logic [17:0] pgn, logic [6:0] len,
                                             logic [63:0] lo, logic [63:0] hi);
    gpmd_pkg::in_t m;
    m.pgn          = pgn;
    m.length       = len;
    m.payload_low  = lo;
    m.payload_high = hi;
    return m;
  endfunction

  function automatic gpmd_pkg::in_t position_msg(logic [6:0] len, logic [31:0] lat,
                                                 logic [31:0] lon, logic [31:0] alt,
                                                 logic [7:0] sats, logic [7:0] hdop,
                                                 logic [7:0] status);
    return make_msg(gpmd_pkg::PgnPosition, len, {lon, lat},
                    {status, hdop, sats, 8'($urandom), alt});
  endfunction

  function automatic gpmd_pkg::in_t wide_msg(logic [6:0] len, logic [31:0] dlat,
                                             logic [31:0] dlon, logic [31:0] dalt);
    return make_msg(gpmd_pkg::PgnDeltaWide, len, {dlon, dlat}, {32'($urandom), dalt});
  endfunction

  function automatic gpmd_pkg::in_t short_msg(logic [6:0] len, logic [15:0] dlat,
                                              logic [15:0] dlon, logic [15:0] dalt);
    return make_msg(gpmd_pkg::PgnDelta, len, {16'($urandom), dalt, dlon, dlat},
                    rand64());
  endfunction

  // Mostly valid lengths, now and then far past the sixteen real bytes.
  function automatic logic [6:0] good_len(int shortest);
    if ($urandom_range(9) == 0) return 7'($urandom_range(127, 17));
    return 7'($urandom_range(16, shortest));
  endfunction

  function automatic gpmd_pkg::in_t random_message();
    int          pick;
    logic [17:0] pgn;
    pick = $urandom_range(99);
    if (pick < 25) return make_msg(gpmd_pkg::PgnPosition, good_len(8), rand64(), rand64());
    if (pick < 50) return make_msg(gpmd_pkg::PgnDelta, good_len(8), rand64(), rand64());
    if (pick < 72) begin
      return make_msg(gpmd_pkg::PgnDeltaWide, good_len(12), rand64(), rand64());
    end
    if (pick < 80) begin
      pgn = $urandom_range(1) ? gpmd_pkg::PgnCovariance : gpmd_pkg::PgnDeltaCovariance;
      return make_msg(pgn, 7'($urandom), rand64(), rand64());
    end
    if (pick < 90) begin
      // Known message type cut short of its minimum length.
      case ($urandom_range(2))
        0: begin
          return make_msg(gpmd_pkg::PgnPosition, 7'($urandom_range(7)), rand64(), rand64());
        end
        1: begin
          return make_msg(gpmd_pkg::PgnDelta, 7'($urandom_range(7)), rand64(), rand64());
        end
        default: begin
          return make_msg(gpmd_pkg::PgnDeltaWide, 7'($urandom_range(11)), rand64(),
                          rand64());
        end
      endcase
    end
    pgn = $urandom_range(1) ? 18'($urandom) : ($urandom_range(1) ? 18'd65266 : 18'd65272);
    return make_msg(pgn, 7'($urandom), rand64(), rand64());
  endfunction

  // Entered and left at a falling edge; returns once the transfer has happened.
  task automatic send_item(input gpmd_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    msgs_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] big_step(bit up);
    return up ? $urandom_range(32'h7FFF_FFFF, 32'h7F00_0000)
              : $urandom_range(32'h80FF_FFFF, 32'h8000_0000);
  endfunction

  // Pushes each accumulator into its positive or negative clamp and keeps
  // pressing on it with both delta formats.
  task automatic drift_run(input bit [2:0] up);
    send_item(position_msg(7'd16, up[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                           up[1] ? 32'h7FFF_FFFF : 32'h8000_0000,
                           up[2] ? 32'h7FFF_FFFF : 32'h8000_0000,
                           8'($urandom), 8'($urandom), 8'($urandom)));
    repeat (DriftSteps) begin
      send_item(wide_msg(good_len(12), big_step(up[0]), big_step(up[1]), big_step(up[2])));
    end
    repeat (15) begin
      send_item(short_msg(7'd8, up[0] ? 16'h7FFF : 16'h8000,
                          up[1] ? 16'h7FFF : 16'h8000, up[2] ? 16'h7FFF : 16'h8000));
    end
  endtask

  task automatic run_directed();
    send_item(make_msg(18'd0, 7'd0, '0, '0));
    send_item(make_msg(18'h3FFFF, 7'h7F, '1, '1));
    // Deltas before any position is known leave the solution untouched.
    send_item(short_msg(7'd8, 16'h1234, 16'hFEDC, 16'h7FFF));
    send_item(wide_msg(7'd12, 32'h0100_0000, 32'hFF00_0000, 32'h7FFF_FFFF));
    send_item(position_msg(7'd7, 32'h1, 32'h2, 32'h3, 8'd4, 8'd5, 8'h0F));
    send_item(position_msg(7'd8, 32'h7FFF_FFFF, 32'h8000_0000, '1, '1, '1, '1));
    // Altitude is still absent, so its delta is dropped.
    send_item(short_msg(7'd8, 16'h7FFF, 16'h8000, 16'h1234));
    send_item(short_msg(7'd7, 16'h0001, 16'h0001, 16'h0001));
    send_item(wide_msg(7'd11, 32'h1, 32'h1, 32'h1));
    send_item(position_msg(7'd12, 32'h0, 32'h0, 32'h8000_0000, '1, '1, '1));
    send_item(position_msg(7'd13, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1));
    send_item(position_msg(7'd14, 32'h2, 32'h3, 32'h4, 8'hFF, 8'hFF, 8'hFF));
    send_item(position_msg(7'd15, 32'h5, 32'h6, 32'h7, 8'h00, 8'hFF, 8'hFF));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h00, 8'h00));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h50, 8'h01));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h50, 8'h02));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h50, 8'h08));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h50, 8'h0F));
    send_item(position_msg(7'd16, 32'h8, 32'h9, 32'hA, 8'h0C, 8'h50, 8'hF0));
    send_item(make_msg(gpmd_pkg::PgnPosition, 7'h7F, '1, '1));
    send_item(wide_msg(7'd12, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(make_msg(gpmd_pkg::PgnCovariance, 7'd0, rand64(), rand64()));
    send_item(make_msg(gpmd_pkg::PgnDeltaCovariance, 7'h7F, rand64(), rand64()));
    send_item(make_msg(18'd65266, 7'd16, rand64(), rand64()));
    send_item(make_msg(18'd65272, 7'd16, rand64(), rand64()));
    directed_count = msgs_sent;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (PhaseItems) send_item(random_message());
    in_valid = 1'b0;
    wait (n_pending == 0);
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off whenever requested.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !hold_served) begin
        out_ready   = 1'b0;
        hold_served = 1'b1;
        repeat (HoldLen) @(negedge clk);
      end
      if (!long_hold) hold_served = 1'b0;
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    in_valid = 1'b0;
    wait (n_pending == 0);
    @(negedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drift_run(3'($urandom));
    // Keep offering messages while the result side is held off, so the
    // pipeline fills and pushes back on the input.
    long_hold = 1'b1;
    repeat (40) send_item(random_message());
    long_hold = 1'b0;
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    recv_stall_pct = 0;
    drift_run(~u_checker_up_hint());
    run_phase(32, 32);

    in_valid = 1'b0;
    wait (n_pending == 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d messages (%0d directed), %0d results compared.",
             msgs_sent, directed_count, n_checked);
    $display("Accumulator clamps hit: %0d, across four stall patterns and one long hold-off.",
             n_clamped);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Second drift goes in a random direction as well; kept apart so the call
  // above reads as the opposite of a fresh draw.
  function automatic bit [2:0] u_checker_up_hint();
    return 3'($urandom);
  endfunction

endmodule
